// ===== hdl/alla_pkg.sv =====
package alla_pkg;

    localparam int LUX_FRAC_BITS_DEF = 10;

    localparam int RAW_W      = 16;
    localparam int LUX_W      = 38;
    localparam int GAIN_W     = 2;
    localparam int CODE_W     = 3;
    localparam int LIMIT_W    = 16;
    localparam int SHIFT_W    = 4;
    localparam int RES_W      = 25;
    localparam int LIN_PROD_W = RAW_W + RES_W;
    localparam int LIN_W      = 50;
    localparam int LIN_FRAC   = 16;
    localparam int X_W        = 34;
    localparam int MAG_W      = 64;
    localparam int LIMB_W     = 32;
    localparam int PROD_W     = X_W + LIMB_W;
    localparam int ACC_W      = X_W + MAG_W;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [RES_W-1:0]        RES_Q32 = 25'd18038863;
    localparam logic [MAG_W-1:0]        C4_Q80  = 64'd726987541625;
    localparam logic signed [MAG_W-1:0] C3_Q72  = -64'sd44354354953705;
    localparam logic signed [MAG_W-1:0] C2_Q56  = 64'sd5871829222963;
    localparam logic signed [MAG_W-1:0] C1_Q46  = 64'sd70530592289273;
    localparam logic [LUX_W-1:0]        LUX_MAX = '1;

    localparam int SH_H3 = 24;
    localparam int SH_H2 = 32;
    localparam int SH_H1 = 26;

    localparam logic [GAIN_W-1:0] GAIN_X1_8 = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_X1_4 = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_X2   = 2'd3;

    localparam logic [CODE_W-1:0] CODE_100MS = 3'd2;
    localparam logic [CODE_W-1:0] CODE_800MS = 3'd5;

    localparam logic [2:0] REG_INTEG      = 3'd0;
    localparam logic [2:0] REG_START_GAIN = 3'd1;
    localparam logic [2:0] REG_AUTO_GAIN  = 3'd2;
    localparam logic [2:0] REG_HIGH_LIMIT = 3'd3;
    localparam logic [2:0] REG_LOW_LIMIT  = 3'd4;

    localparam logic [CODE_W-1:0]  INTEG_RST = CODE_100MS;
    localparam logic [GAIN_W-1:0]  START_GAIN_RST = GAIN_X1_8;
    localparam logic               AUTO_GAIN_RST = 1'b1;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 16'd10000;
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFORM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_RND,
        ST_FOLD,
        ST_DONE
    } alla_state_t;

    typedef enum logic [1:0] {
        STEP_H3,
        STEP_H2,
        STEP_H1,
        STEP_LUX
    } alla_step_t;

    typedef struct packed {
        logic       take;
        logic       xform;
        logic       mul_lo;
        logic       mul_hi;
        logic       acc_hi;
        logic       rnd;
        logic       fold;
        logic       out_load;
        alla_step_t step;
    } alla_cmd_t;

    typedef struct packed {
        logic h_nonpos;
    } alla_stat_t;

    function automatic logic [SHIFT_W-1:0] lin_shift(input logic [CODE_W-1:0] code,
                                                     input logic [GAIN_W-1:0] gain);
        logic [CODE_W-1:0]  c;
        logic [SHIFT_W-1:0] g;
        c = (code > CODE_800MS) ? CODE_100MS : code;
        case (gain)
            GAIN_X1_8: g = 4'd4;
            GAIN_X1_4: g = 4'd3;
            GAIN_X1:   g = 4'd1;
            default:   g = 4'd0;
        endcase
        return SHIFT_W'(CODE_800MS - c) + g;
    endfunction

endpackage

// ===== hdl/alla_ctrl.sv =====
module alla_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output alla_pkg::alla_cmd_t   cmd,
    input  alla_pkg::alla_stat_t  stat
);
    import alla_pkg::*;

    alla_state_t state_reg, state_next;
    alla_step_t  step_reg, step_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_H3;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        cmd.step     = step_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_XFORM;
                end
            end
            ST_XFORM: begin
                cmd.xform  = 1'b1;
                step_next  = STEP_H3;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                if (step_reg == STEP_LUX && stat.h_nonpos) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mul_lo = 1'b1;
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_hi = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = (step_reg == STEP_LUX) ? ST_DONE : ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold   = 1'b1;
                step_next  = alla_step_t'(step_reg + 2'd1);
                state_next = ST_MUL_LO;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/alla_dp.sv =====
module alla_dp #(
    parameter int LUX_FRAC_BITS = alla_pkg::LUX_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  alla_pkg::alla_cmd_t          cmd,
    output alla_pkg::alla_stat_t         stat,
    input  logic [alla_pkg::RAW_W-1:0]   raw_count,
    input  logic [alla_pkg::CODE_W-1:0]  integration_code,
    input  logic                         auto_gain_enable,
    input  logic [alla_pkg::LIMIT_W-1:0] high_count_limit,
    input  logic [alla_pkg::LIMIT_W-1:0] low_count_limit,
    input  logic                         gain_load,
    input  logic [alla_pkg::GAIN_W-1:0]  gain_load_value,
    output logic [alla_pkg::LUX_W-1:0]   lux_fixed,
    output logic [alla_pkg::GAIN_W-1:0]  gain_used,
    output logic [alla_pkg::GAIN_W-1:0]  next_gain,
    output logic                         gain_changed,
    output logic                         lux_saturated
);
    import alla_pkg::*;

    localparam int SH_LUX = 62 - LUX_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF_H3  = ACC_W'(1) << (SH_H3 - 1);
    localparam logic [ACC_W-1:0] HALF_H2  = ACC_W'(1) << (SH_H2 - 1);
    localparam logic [ACC_W-1:0] HALF_H1  = ACC_W'(1) << (SH_H1 - 1);
    localparam logic [ACC_W-1:0] HALF_LUX = ACC_W'(1) << (SH_LUX - 1);
    localparam logic [LIN_W-1:0] LIN_HALF = LIN_W'(1) << (LIN_FRAC - 1);

    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [GAIN_W-1:0]   used_reg, used_next;
    logic [GAIN_W-1:0]   adj_reg, adj_next;
    logic                changed_reg, changed_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [MAG_W-1:0]    rnd_reg, rnd_next;
    logic [LUX_W-1:0]    lux_reg, lux_next;
    logic [GAIN_W-1:0]   out_used_reg, out_used_next;
    logic [GAIN_W-1:0]   out_next_reg, out_next_next;
    logic                out_changed_reg, out_changed_next;
    logic                out_sat_reg, out_sat_next;

    logic                      step_dn, step_up;
    logic [GAIN_W-1:0]         gain_adj;
    logic [LIN_PROD_W-1:0]     lin_prod;
    logic [LIN_W-1:0]          lin_round;
    logic [LIMB_W-1:0]         limb;
    logic [PROD_W-1:0]         mul_prod;
    logic [MAG_W-1:0]          rnd_val;
    logic signed [MAG_W-1:0]   term;
    logic signed [MAG_W-1:0]   h_base;
    logic signed [MAG_W-1:0]   h_fold;
    logic                      lux_over;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_X1_8;
        end else begin
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge aclk) begin
        used_reg        <= used_next;
        adj_reg         <= adj_next;
        changed_reg     <= changed_next;
        shift_reg       <= shift_next;
        prod_reg        <= prod_next;
        x_reg           <= x_next;
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        acc_reg         <= acc_next;
        rnd_reg         <= rnd_next;
        lux_reg         <= lux_next;
        out_used_reg    <= out_used_next;
        out_next_reg    <= out_next_next;
        out_changed_reg <= out_changed_next;
        out_sat_reg     <= out_sat_next;
    end

    always_comb begin
        step_dn  = auto_gain_enable && (raw_count > high_count_limit) && (gain_reg != GAIN_X1_8);
        step_up  = auto_gain_enable && !(raw_count > high_count_limit)
                   && (raw_count < low_count_limit) && (gain_reg != GAIN_X2);
        gain_adj = step_dn ? gain_reg - 2'd1 : (step_up ? gain_reg + 2'd1 : gain_reg);

        lin_prod  = LIN_PROD_W'(raw_count) * LIN_PROD_W'(RES_Q32);
        lin_round = (LIN_W'(prod_reg[LIN_PROD_W-1:0]) << shift_reg) + LIN_HALF;

        limb     = cmd.mul_hi ? mag_reg[MAG_W-1:LIMB_W] : mag_reg[LIMB_W-1:0];
        mul_prod = PROD_W'(x_reg) * PROD_W'(limb);

        case (cmd.step)
            STEP_H3: rnd_val = MAG_W'((acc_reg + HALF_H3) >> SH_H3);
            STEP_H2: rnd_val = MAG_W'((acc_reg + HALF_H2) >> SH_H2);
            STEP_H1: rnd_val = MAG_W'((acc_reg + HALF_H1) >> SH_H1);
            default: rnd_val = MAG_W'((acc_reg + HALF_LUX) >> SH_LUX);
        endcase

        case (cmd.step)
            STEP_H3: h_base = C3_Q72;
            STEP_H2: h_base = C2_Q56;
            default: h_base = C1_Q46;
        endcase
        term   = neg_reg ? -$signed(rnd_reg) : $signed(rnd_reg);
        h_fold = h_base + term;

        stat.h_nonpos = neg_reg || (mag_reg == '0);
        lux_over      = rnd_reg > MAG_W'(LUX_MAX);

        gain_next        = gain_reg;
        used_next        = used_reg;
        adj_next         = adj_reg;
        changed_next     = changed_reg;
        shift_next       = shift_reg;
        prod_next        = prod_reg;
        x_next           = x_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        rnd_next         = rnd_reg;
        lux_next         = lux_reg;
        out_used_next    = out_used_reg;
        out_next_next    = out_next_reg;
        out_changed_next = out_changed_reg;
        out_sat_next     = out_sat_reg;

        if (gain_load) begin
            gain_next = gain_load_value;
        end else if (cmd.take) begin
            gain_next = gain_adj;
        end

        if (cmd.take) begin
            used_next    = gain_reg;
            adj_next     = gain_adj;
            changed_next = step_dn | step_up;
            shift_next   = lin_shift(integration_code, gain_reg);
            prod_next    = PROD_W'(lin_prod);
        end

        if (cmd.xform) begin
            x_next   = lin_round[LIN_W-1:LIN_FRAC];
            mag_next = C4_Q80;
            neg_next = 1'b0;
        end

        if (cmd.mul_lo || cmd.mul_hi) begin
            prod_next = mul_prod;
        end
        if (cmd.mul_hi) begin
            acc_next = ACC_W'(prod_reg);
        end
        if (cmd.acc_hi) begin
            acc_next = acc_reg + (ACC_W'(prod_reg) << LIMB_W);
        end
        if (cmd.rnd) begin
            rnd_next = rnd_val;
        end
        if (cmd.fold) begin
            neg_next = h_fold[MAG_W-1];
            mag_next = h_fold[MAG_W-1] ? $unsigned(-h_fold) : $unsigned(h_fold);
        end

        if (cmd.out_load) begin
            out_used_next    = used_reg;
            out_next_next    = adj_reg;
            out_changed_next = changed_reg;
            if (stat.h_nonpos) begin
                lux_next     = '0;
                out_sat_next = 1'b0;
            end else if (lux_over) begin
                lux_next     = LUX_MAX;
                out_sat_next = 1'b1;
            end else begin
                lux_next     = rnd_reg[LUX_W-1:0];
                out_sat_next = 1'b0;
            end
        end
    end

    assign lux_fixed     = lux_reg;
    assign gain_used     = out_used_reg;
    assign next_gain     = out_next_reg;
    assign gain_changed  = out_changed_reg;
    assign lux_saturated = out_sat_reg;

endmodule

// ===== hdl/ambient_light_lux_autogain.sv =====
// Ambient light lux conversion with automatic gain stepping.
// Input channel (s_valid/s_ready, s_raw_count): one raw 16-bit light count
// per item. Result channel (m_valid/m_ready): corrected lux in units of
// 2^-LUX_FRAC_BITS lux, the gain applied, the gain kept for the next item,
// and flags for a gain step and for a clipped lux value.
// Configuration goes through the APB port, one 32-bit register per word:
// integration code, start gain (a write loads the kept gain), auto-gain
// enable, high and low count limits. pready is always high.
// After acceptance, the item passes through the input transform and then the
// Horner steps; the last (lux) step is skipped when the polynomial is not
// positive. The single 34x32 multiplier works through the eight partial
// products of the four Horner steps.
// s_ready is high only while the block is idle; a finished result waits in
// the output register, and the next item is accepted meanwhile. If the
// receiver still stalls when the next result is ready, the block holds it
// until the output register frees.
// Reset (aresetn low at a clock edge) drops any item in flight, clears
// m_valid and loads the register defaults and gain x1/8.
module ambient_light_lux_autogain #(
    parameter int LUX_FRAC_BITS = alla_pkg::LUX_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [alla_pkg::RAW_W-1:0]   s_raw_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [alla_pkg::LUX_W-1:0]   m_lux_fixed,
    output logic [alla_pkg::GAIN_W-1:0]  m_gain_used,
    output logic [alla_pkg::GAIN_W-1:0]  m_next_gain,
    output logic                         m_gain_changed,
    output logic                         m_lux_saturated,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [alla_pkg::PADDR_W-1:0] paddr,
    input  logic [alla_pkg::PDATA_W-1:0] pwdata,
    output logic [alla_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import alla_pkg::*;

    logic [CODE_W-1:0]  integ_reg, integ_next;
    logic [GAIN_W-1:0]  start_gain_reg, start_gain_next;
    logic               auto_gain_reg, auto_gain_next;
    logic [LIMIT_W-1:0] high_limit_reg, high_limit_next;
    logic [LIMIT_W-1:0] low_limit_reg, low_limit_next;

    logic               wr_en;
    logic [2:0]         reg_idx;
    logic               gain_load;
    alla_cmd_t          cmd;
    alla_stat_t         stat;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg      <= INTEG_RST;
            start_gain_reg <= START_GAIN_RST;
            auto_gain_reg  <= AUTO_GAIN_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
            low_limit_reg  <= LOW_LIMIT_RST;
        end else begin
            integ_reg      <= integ_next;
            start_gain_reg <= start_gain_next;
            auto_gain_reg  <= auto_gain_next;
            high_limit_reg <= high_limit_next;
            low_limit_reg  <= low_limit_next;
        end
    end

    always_comb begin
        integ_next      = integ_reg;
        start_gain_next = start_gain_reg;
        auto_gain_next  = auto_gain_reg;
        high_limit_next = high_limit_reg;
        low_limit_next  = low_limit_reg;
        gain_load       = 1'b0;
        if (wr_en) begin
            case (reg_idx)
                REG_INTEG:      integ_next = pwdata[CODE_W-1:0];
                REG_START_GAIN: begin
                    start_gain_next = pwdata[GAIN_W-1:0];
                    gain_load       = 1'b1;
                end
                REG_AUTO_GAIN:  auto_gain_next = pwdata[0];
                REG_HIGH_LIMIT: high_limit_next = pwdata[LIMIT_W-1:0];
                REG_LOW_LIMIT:  low_limit_next = pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INTEG:      prdata = PDATA_W'(integ_reg);
            REG_START_GAIN: prdata = PDATA_W'(start_gain_reg);
            REG_AUTO_GAIN:  prdata = PDATA_W'(auto_gain_reg);
            REG_HIGH_LIMIT: prdata = PDATA_W'(high_limit_reg);
            REG_LOW_LIMIT:  prdata = PDATA_W'(low_limit_reg);
            default:        prdata = '0;
        endcase
    end

    alla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    alla_dp #(
        .LUX_FRAC_BITS (LUX_FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .raw_count        (s_raw_count),
        .integration_code (integ_reg),
        .auto_gain_enable (auto_gain_reg),
        .high_count_limit (high_limit_reg),
        .low_count_limit  (low_limit_reg),
        .gain_load        (gain_load),
        .gain_load_value  (pwdata[GAIN_W-1:0]),
        .lux_fixed        (m_lux_fixed),
        .gain_used        (m_gain_used),
        .next_gain        (m_next_gain),
        .gain_changed     (m_gain_changed),
        .lux_saturated    (m_lux_saturated)
    );

endmodule

// ===== hdl/alla_checker.sv =====
module alla_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [alla_pkg::LUX_W-1:0]  m_lux_fixed,
    input logic [alla_pkg::GAIN_W-1:0] m_gain_used,
    input logic [alla_pkg::GAIN_W-1:0] m_next_gain,
    input logic                        m_gain_changed,
    input logic                        m_lux_saturated
);
    import alla_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lux_fixed) && $stable(m_next_gain))
        else $error("result item changed while stalled");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_sat_clips: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lux_saturated |-> m_lux_fixed == LUX_MAX)
        else $error("saturated item without full-scale lux");

    a_gain_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_gain_changed |-> m_next_gain == m_gain_used)
        else $error("gain moved without gain_changed");

    a_gain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gain_changed |->
            (m_next_gain == m_gain_used + 2'd1) || (m_gain_used == m_next_gain + 2'd1))
        else $error("gain step larger than one");

endmodule

bind ambient_light_lux_autogain alla_checker u_alla_checker (.*);
